FILE: design/ahfd_pkg.sv
// ----------------------------------------------------------------------------
// ahfd_pkg
// Shared types, constants and the hex digit decoder for the ASCII hex frame
// deframer.
// ----------------------------------------------------------------------------
package ahfd_pkg;

    localparam int unsigned HDR_CHARS = 23;
    localparam int unsigned IV_BYTES  = 12;
    localparam int unsigned TAG_BYTES = 16;

    localparam logic [7:0] SEP_CHAR = 8'h3A;  // ':'

    localparam logic [4:0] POS_COLON0 = 5'd2;
    localparam logic [4:0] POS_COLON1 = 5'd7;
    localparam logic [4:0] POS_COLON2 = 5'd12;
    localparam logic [4:0] POS_COLON3 = 5'd17;
    localparam logic [4:0] POS_LAST   = 5'(HDR_CHARS - 1);

    localparam logic [1:0] KIND_HDR_OK  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_HDR_BAD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  option_byte;
        logic [15:0] source_id;
        logic [15:0] dest_id;
        logic [15:0] payload_len;
        logic [15:0] frame_count;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    // Strict hex digit; anything else decodes to zero with ok low.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.val = 4'(c - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: design/ascii_hex_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_deframer_unit
// An accepted input beat is held in the input register; its result is held in the result register.
// Throughput: one character per cycle while out_ready does not stall; a character yields zero or one result.
// Rate is set by the input register / result register pair around the step.
// Reset (rst_n, async, active low) empties both registers and starts a header.
// ----------------------------------------------------------------------------
module ascii_hex_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  option_byte,
    output logic [15:0] source_id,
    output logic [15:0] dest_id,
    output logic [15:0] payload_len,
    output logic [15:0] frame_count,
    output logic [7:0]  data_byte,
    output logic        last
);

    logic              in_valid_reg;
    logic [7:0]        char_reg;
    logic              out_valid_reg;
    ahfd_pkg::result_t res_reg;

    logic              advance;
    logic              fire;
    logic              res_valid;
    ahfd_pkg::result_t res;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    ahfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_in   (char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire && res_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_in;
        end
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = res_reg.kind;
    assign option_byte = res_reg.option_byte;
    assign source_id   = res_reg.source_id;
    assign dest_id     = res_reg.dest_id;
    assign payload_len = res_reg.payload_len;
    assign frame_count = res_reg.frame_count;
    assign data_byte   = res_reg.data_byte;
    assign last        = res_reg.last;

endmodule

FILE: design/ahfd_core.sv
// ----------------------------------------------------------------------------
// ahfd_core
// Frame state and the per-character step: header parse and check, payload
// nibble pairing and byte count.
// ----------------------------------------------------------------------------
module ahfd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        char_in,
    output logic              res_valid,
    output ahfd_pkg::result_t res
);

    logic [4:0]  header_pos_reg, header_pos_next;
    logic        in_payload_reg, in_payload_next;
    logic        header_good_reg, header_good_next;
    logic [7:0]  opt_acc_reg, opt_acc_next;
    logic [15:0] src_acc_reg, src_acc_next;
    logic [15:0] dst_acc_reg, dst_acc_next;
    logic [15:0] len_acc_reg, len_acc_next;
    logic [15:0] cnt_acc_reg, cnt_acc_next;
    logic [17:0] hex_left_reg, hex_left_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        nibble_pending_reg, nibble_pending_next;

    ahfd_pkg::hex_digit_t dig;
    logic        colon_here;
    logic        good_w;
    logic [17:0] left_dec;

    always_comb
    begin
        dig        = ahfd_pkg::hex_decode(char_in);
        colon_here = (header_pos_reg == ahfd_pkg::POS_COLON0) ||
                     (header_pos_reg == ahfd_pkg::POS_COLON1) ||
                     (header_pos_reg == ahfd_pkg::POS_COLON2) ||
                     (header_pos_reg == ahfd_pkg::POS_COLON3) ||
                     (header_pos_reg == ahfd_pkg::POS_LAST);
        good_w     = header_good_reg &
                     (colon_here ? (char_in == ahfd_pkg::SEP_CHAR) : dig.ok);
        left_dec   = hex_left_reg - 18'(hex_left_reg != 18'd0);

        header_pos_next     = header_pos_reg;
        in_payload_next     = in_payload_reg;
        header_good_next    = header_good_reg;
        opt_acc_next        = opt_acc_reg;
        src_acc_next        = src_acc_reg;
        dst_acc_next        = dst_acc_reg;
        len_acc_next        = len_acc_reg;
        cnt_acc_next        = cnt_acc_reg;
        hex_left_next       = hex_left_reg;
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (in_payload_reg)
        begin
            hex_left_next = left_dec;
            if (!nibble_pending_reg)
            begin
                high_nibble_next    = dig.val;
                nibble_pending_next = 1'b1;
            end
            else
            begin
                nibble_pending_next = 1'b0;
                res_valid           = 1'b1;
                res.kind            = ahfd_pkg::KIND_DATA;
                res.data_byte       = {high_nibble_reg, dig.val};
                if (left_dec == 18'd0)
                begin
                    res.last        = 1'b1;
                    in_payload_next = 1'b0;
                end
            end
        end
        else
        begin
            if (!colon_here)
            begin
                if (header_pos_reg < ahfd_pkg::POS_COLON0)
                begin
                    opt_acc_next = {opt_acc_reg[3:0], dig.val};
                end
                else if (header_pos_reg < ahfd_pkg::POS_COLON1)
                begin
                    src_acc_next = {src_acc_reg[11:0], dig.val};
                end
                else if (header_pos_reg < ahfd_pkg::POS_COLON2)
                begin
                    dst_acc_next = {dst_acc_reg[11:0], dig.val};
                end
                else if (header_pos_reg < ahfd_pkg::POS_COLON3)
                begin
                    len_acc_next = {len_acc_reg[11:0], dig.val};
                end
                else
                begin
                    cnt_acc_next = {cnt_acc_reg[11:0], dig.val};
                end
            end

            if (header_pos_reg != ahfd_pkg::POS_LAST)
            begin
                header_pos_next  = header_pos_reg + 5'd1;
                header_good_next = good_w;
            end
            else
            begin
                // last header char is a colon, so the fields are complete
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (good_w)
                begin
                    res.kind        = ahfd_pkg::KIND_HDR_OK;
                    res.option_byte = opt_acc_reg;
                    res.source_id   = src_acc_reg;
                    res.dest_id     = dst_acc_reg;
                    res.payload_len = len_acc_reg;
                    res.frame_count = cnt_acc_reg;
                    if (len_acc_reg != 16'd0)
                    begin
                        res.last            = 1'b0;
                        in_payload_next     = 1'b1;
                        nibble_pending_next = 1'b0;
                        high_nibble_next    = 4'd0;
                        hex_left_next       = (18'(len_acc_reg) +
                            18'(ahfd_pkg::IV_BYTES + ahfd_pkg::TAG_BYTES)) << 1;
                    end
                end
                else
                begin
                    res.kind = ahfd_pkg::KIND_HDR_BAD;
                end
                header_pos_next  = 5'd0;
                header_good_next = 1'b1;
                opt_acc_next     = 8'd0;
                src_acc_next     = 16'd0;
                dst_acc_next     = 16'd0;
                len_acc_next     = 16'd0;
                cnt_acc_next     = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg     <= 5'd0;
            in_payload_reg     <= 1'b0;
            header_good_reg    <= 1'b1;
            opt_acc_reg        <= 8'd0;
            src_acc_reg        <= 16'd0;
            dst_acc_reg        <= 16'd0;
            len_acc_reg        <= 16'd0;
            cnt_acc_reg        <= 16'd0;
            hex_left_reg       <= 18'd0;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            header_pos_reg     <= header_pos_next;
            in_payload_reg     <= in_payload_next;
            header_good_reg    <= header_good_next;
            opt_acc_reg        <= opt_acc_next;
            src_acc_reg        <= src_acc_next;
            dst_acc_reg        <= dst_acc_next;
            len_acc_reg        <= len_acc_next;
            cnt_acc_reg        <= cnt_acc_next;
            hex_left_reg       <= hex_left_next;
            high_nibble_reg    <= high_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
        end
    end

endmodule
